// ===== design/nft_pkg.sv =====
// Shared constants, types and codes for the RSSI noise floor tracker.
package nft_pkg;

   localparam int WINDOW_DEPTH  = 10;
   localparam int CHAN_W        = 1;
   localparam int CHANNEL_COUNT = 2 ** CHAN_W;
   localparam int FILL_W        = $clog2(WINDOW_DEPTH + 1);
   localparam int IDX_W         = $clog2(WINDOW_DEPTH);
   localparam int FILL_OUT_W    = 4;
   localparam int RSSI_W        = 8;
   localparam int TIME_W        = 32;
   localparam int PERIOD_W      = 16;

   typedef logic [RSSI_W-1:0]     rssi_type;
   typedef rssi_type [WINDOW_DEPTH-1:0] row_type;
   typedef logic [FILL_W-1:0]     fill_type;
   typedef logic [FILL_OUT_W-1:0] fill_out_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [CHAN_W-1:0]     chan_type;
   typedef logic [TIME_W-1:0]     time_type;
   typedef logic [PERIOD_W-1:0]   period_type;

   localparam rssi_type   EMPTY_FLOOR    = 8'hFF;
   localparam period_type PERIOD_DEFAULT = 16'd180;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_TICK   = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RANK,
      ST_DONE
   } state_type;

   // Update request from the sequencer to the window store
   typedef struct packed {
      logic     clear_all;
      logic     fill_we;
      logic     push;
      chan_type chan;
      fill_type fill;
      rssi_type value;
   } win_cmd_type;

   // Key presented to the rank unit
   typedef struct packed {
      rssi_type key;
      idx_type  key_idx;
      logic     tie_en;
   } rank_req_type;

endpackage

// ===== design/nft_req_if.sv =====
// Request channel interface: commands and samples into the tracker.
interface nft_req_if;
   import nft_pkg::*;

   logic     valid;
   logic     ready;
   cmd_type  command;
   chan_type channel;
   rssi_type rssi;
   time_type utc_time;

   modport source (output valid, output command, output channel, output rssi,
                   output utc_time, input ready);
   modport sink   (input valid, input command, input channel, input rssi,
                   input utc_time, output ready);
endinterface

// ===== design/nft_rsp_if.sv =====
// Response channel interface: reported noise floor per channel.
interface nft_rsp_if;
   import nft_pkg::*;

   logic         valid;
   logic         ready;
   chan_type     floor_channel;
   rssi_type     noise_floor;
   fill_out_type window_fill;

   modport source (output valid, output floor_channel, output noise_floor,
                   output window_fill, input ready);
   modport sink   (input valid, input floor_channel, input noise_floor,
                   input window_fill, output ready);
endinterface

// ===== design/nft_rank_unit.sv =====
// Shared compare unit: counts held readings that order below a key.
module nft_rank_unit (
   input  nft_pkg::row_type      row,
   input  nft_pkg::fill_type     count_n,
   input  nft_pkg::rank_req_type rank_req,
   output nft_pkg::fill_type     rank
);
   import nft_pkg::*;

   logic [WINDOW_DEPTH-1:0] below;

   // With tie_en set, ties break on position so every held entry gets a distinct rank
   always_comb begin
      for (int j = 0; j < WINDOW_DEPTH; j++) begin
         below[j] = (FILL_W'(j) < count_n) &&
                    ((row[j] < rank_req.key) ||
                     (rank_req.tie_en && (row[j] == rank_req.key) &&
                      (IDX_W'(j) < rank_req.key_idx)));
      end
      rank = FILL_W'($countones(below));
   end

endmodule

// ===== design/nft_window.sv =====
// Per-channel reading windows with front insertion and fill counts.
module nft_window (
   input  logic                 clock,
   input  logic                 reset,
   input  nft_pkg::win_cmd_type cmd,
   input  nft_pkg::chan_type    rd_chan,
   output nft_pkg::row_type     rd_row,
   output nft_pkg::fill_type    rd_fill
);
   import nft_pkg::*;

   row_type  rows_ff  [CHANNEL_COUNT];
   fill_type fills_ff [CHANNEL_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNEL_COUNT; c++) begin
            fills_ff[c] <= '0;
         end
      end else if (cmd.clear_all) begin
         for (int c = 0; c < CHANNEL_COUNT; c++) begin
            fills_ff[c] <= '0;
         end
      end else if (cmd.fill_we) begin
         fills_ff[cmd.chan] <= cmd.fill;
      end
   end

   // Push at the front; the last entry falls off
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rows_ff[cmd.chan] <= {rows_ff[cmd.chan][WINDOW_DEPTH-2:0], cmd.value};
      end
   end

   assign rd_row  = rows_ff[rd_chan];
   assign rd_fill = fills_ff[rd_chan];

endmodule

// ===== design/rssi_noise_floor_tracker_unit.sv =====
// Top level: RSSI noise floor tracker with sequencer and shared rank unit.
// Sequence: accept, then a check step when a sample is checked against a held window,
// then rank steps over the window until the median is found, then done, which loads the output register.
// One word at a time: a new request is taken only once the sequencer is back in idle;
// a stalled response holds the sequencer in done.
// Reset (synchronous, active high): windows empty, time and period start zero, period 180.
module rssi_noise_floor_tracker_unit (
   input  logic                         clock,
   input  logic                         reset,
   nft_req_if.sink                      req_if,
   nft_rsp_if.source                    rsp_if,
   input  logic                         csr_wr_en,
   input  logic [nft_pkg::PERIOD_W-1:0] csr_wr_data
);
   import nft_pkg::*;

   // Sequencer state and the word being worked on
   state_type  state_ff, state_in;
   chan_type   chan_ff, chan_in;
   rssi_type   rssi_ff, rssi_in;
   idx_type    idx_ff, idx_in;
   rssi_type   floor_ff, floor_in;

   // Time keeping and the period register
   time_type   time_ff, time_in;
   time_type   pstart_ff, pstart_in;
   period_type period_ff;

   // Output register: holds a finished word while the sink stalls
   logic         rsp_valid_ff, rsp_valid_in;
   chan_type     rsp_chan_ff, rsp_chan_in;
   rssi_type     rsp_floor_ff, rsp_floor_in;
   fill_out_type rsp_fill_ff, rsp_fill_in;

   win_cmd_type  win_cmd;
   chan_type     rd_chan;
   row_type      rd_row;
   fill_type     rd_fill;
   rank_req_type rank_req;
   fill_type     rank;

   time_type     tick_start;
   time_type     tick_diff;
   fill_type     n_trim;

   nft_window u_window (
      .clock   (clock),
      .reset   (reset),
      .cmd     (win_cmd),
      .rd_chan (rd_chan),
      .rd_row  (rd_row),
      .rd_fill (rd_fill)
   );

   nft_rank_unit u_rank (
      .row      (rd_row),
      .count_n  (rd_fill),
      .rank_req (rank_req),
      .rank     (rank)
   );

   // While idle look at the channel being offered, so the trim can be
   // decided in the accept cycle; afterwards stick to the latched channel.
   assign rd_chan = (state_ff == ST_IDLE) ? req_if.channel : chan_ff;

   assign req_if.ready         = (state_ff == ST_IDLE);
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.floor_channel = rsp_chan_ff;
   assign rsp_if.noise_floor   = rsp_floor_ff;
   assign rsp_if.window_fill   = rsp_fill_ff;

   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      rssi_in      = rssi_ff;
      idx_in       = idx_ff;
      floor_in     = floor_ff;
      time_in      = time_ff;
      pstart_in    = pstart_ff;
      rsp_chan_in  = rsp_chan_ff;
      rsp_floor_in = rsp_floor_ff;
      rsp_fill_in  = rsp_fill_ff;
      // Drop the response once the sink takes it
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;

      win_cmd  = '0;
      win_cmd.chan = rd_chan;
      rank_req = '0;

      // A tick at time zero restarts the period at zero too
      tick_start = (req_if.utc_time == '0) ? '0 : pstart_ff;
      tick_diff  = req_if.utc_time - tick_start;
      n_trim     = (rd_fill > FILL_W'(WINDOW_DEPTH - 1)) ?
                   FILL_W'(WINDOW_DEPTH - 1) : rd_fill;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               chan_in  = req_if.channel;
               rssi_in  = req_if.rssi;
               idx_in   = '0;
               state_in = ST_RANK;
               if (req_if.command == CMD_TICK) begin
                  time_in   = req_if.utc_time;
                  pstart_in = tick_start;
                  // Wrapping difference: clear every window past the period
                  if (tick_diff > TIME_W'(period_ff)) begin
                     win_cmd.clear_all = 1'b1;
                     pstart_in         = req_if.utc_time;
                  end
               end else if (time_ff != '0) begin
                  // Trim from the back first; an empty window takes the sample
                  win_cmd.fill_we = 1'b1;
                  if (n_trim == '0) begin
                     win_cmd.push  = 1'b1;
                     win_cmd.value = req_if.rssi;
                     win_cmd.fill  = FILL_W'(1);
                  end else begin
                     win_cmd.fill = n_trim;
                     state_in     = ST_CHECK;
                  end
               end
            end
         end

         ST_CHECK: begin
            // Sample fits if fewer than all held readings are strictly below
            rank_req.key     = rssi_ff;
            rank_req.key_idx = '0;
            rank_req.tie_en  = 1'b0;
            if (rank < rd_fill) begin
               win_cmd.push    = 1'b1;
               win_cmd.value   = rssi_ff;
               win_cmd.fill_we = 1'b1;
               win_cmd.fill    = rd_fill + FILL_W'(1);
            end
            idx_in   = '0;
            state_in = ST_RANK;
         end

         ST_RANK: begin
            // Advance one candidate per cycle until its rank hits fill/2
            rank_req.key     = rd_row[idx_ff];
            rank_req.key_idx = idx_ff;
            rank_req.tie_en  = 1'b1;
            if (rd_fill == '0) begin
               floor_in = EMPTY_FLOOR;
               state_in = ST_DONE;
            end else if (rank == (rd_fill >> 1)) begin
               floor_in = rd_row[idx_ff];
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         ST_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_chan_in  = chan_ff;
               rsp_floor_in = floor_ff;
               rsp_fill_in  = FILL_OUT_W'(rd_fill);
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         time_ff      <= '0;
         pstart_ff    <= '0;
         period_ff    <= PERIOD_DEFAULT;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         time_ff      <= time_in;
         pstart_ff    <= pstart_in;
         if (csr_wr_en) begin
            period_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      chan_ff      <= chan_in;
      rssi_ff      <= rssi_in;
      idx_ff       <= idx_in;
      floor_ff     <= floor_in;
      rsp_chan_ff  <= rsp_chan_in;
      rsp_floor_ff <= rsp_floor_in;
      rsp_fill_ff  <= rsp_fill_in;
   end

endmodule

// ===== design/nft_checker.sv =====
// Port-level checks for the noise floor tracker, bound to the top level.
module nft_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [nft_pkg::RSSI_W-1:0]     noise_floor,
   input logic [nft_pkg::FILL_OUT_W-1:0] window_fill
);
   import nft_pkg::*;

   // A stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(noise_floor))
      else $error("response dropped or changed while stalled");

   // One word at a time: no new request right after one is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> window_fill <= FILL_OUT_W'(WINDOW_DEPTH))
      else $error("window fill above depth");

   a_empty_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (window_fill == '0) |-> noise_floor == EMPTY_FLOOR)
      else $error("empty window reports a floor other than 255");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind rssi_noise_floor_tracker_unit nft_checker u_nft_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .noise_floor (rsp_if.noise_floor),
   .window_fill (rsp_if.window_fill)
);
